// File: sv/v86_pkg.sv
// Package of shared types and constants for the virtual-8086 trap emulator.
`default_nettype none
package v86_pkg;

  localparam int unsigned MEM_ADDR_BITS_DEF = 20;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_EMUL  = 2'd2;
  localparam logic [1:0] FUNC_IRQ   = 2'd3;

  localparam logic       CFG_EXIT_SS = 1'b0;
  localparam logic       CFG_EXIT_SP = 1'b1;

  localparam logic [7:0] OP_PUSHF = 8'h9C;
  localparam logic [7:0] OP_POPF  = 8'h9D;
  localparam logic [7:0] OP_INT   = 8'hCD;
  localparam logic [7:0] OP_IRET  = 8'hCF;
  localparam logic [7:0] OP_CLI   = 8'hFA;
  localparam logic [7:0] OP_STI   = 8'hFB;
  localparam logic [7:0] OP_HLT   = 8'hF4;
  localparam logic [7:0] OP_OPSZ  = 8'h66;

  localparam logic [31:0] FLAG_IF = 32'h0000_0200;
  localparam logic [31:0] FLAG_VM = 32'h0002_0000;
  localparam logic [7:0]  IRQ_LO_BASE = 8'h08;
  localparam logic [7:0]  IRQ_HI_BASE = 8'h70;
  localparam logic [4:0]  MAX_PREFIXES = 5'd15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEMRD,
    ST_FETCH,
    ST_DECODE,
    ST_INTNUM,
    ST_CHKIRET,
    ST_WRITE,
    ST_READ,
    ST_CAPT,
    ST_DONE
  } state_t;

  // What the byte sequencer is doing after the opcode is known.
  typedef enum logic [2:0] {
    SEQ_PUSHF,
    SEQ_POPF,
    SEQ_INT,
    SEQ_IRET
  } seq_t;

  function automatic logic is_prefix(input logic [7:0] b);
    return b == 8'h26 || b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h64 ||
           b == 8'h65 || b == 8'h66 || b == 8'h67 || b == 8'hF0 || b == 8'hF2 ||
           b == 8'hF3;
  endfunction

endpackage
`default_nettype wire

// File: sv/v86_if.sv
// Handshake channel interfaces for the trap emulator.
`default_nettype none
interface v86_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [19:0] mem_addr;
  logic [7:0]  mem_data;
  logic [3:0]  irq_number;
  logic [31:0] ip_in;
  logic [15:0] code_seg_in;
  logic [15:0] stack_ptr_in;
  logic [15:0] stack_seg_in;
  logic [31:0] flags_in;
  modport source (output valid, func, mem_addr, mem_data, irq_number, ip_in,
                  code_seg_in, stack_ptr_in, stack_seg_in, flags_in, input ready);
  modport sink (input valid, func, mem_addr, mem_data, irq_number, ip_in,
                code_seg_in, stack_ptr_in, stack_seg_in, flags_in, output ready);
endinterface

interface v86_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ip_out;
  logic [15:0] code_seg_out;
  logic [15:0] stack_ptr_out;
  logic [31:0] flags_out;
  logic        exit_monitor;
  logic        exit_code;
  logic [7:0]  read_data;
  modport source (output valid, ip_out, code_seg_out, stack_ptr_out, flags_out,
                  exit_monitor, exit_code, read_data, input ready);
  modport sink (input valid, ip_out, code_seg_out, stack_ptr_out, flags_out,
                exit_monitor, exit_code, read_data, output ready);
endinterface

interface v86_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/v86_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module v86_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: sv/vm86_trap_emulator.sv
// Top level of the virtual-8086 trap emulator.
// Each item is handled alone; the single-port guest memory moves one byte at a time.
// Memory writes and reads move one byte; CLI/STI/HLT fetch each prefix byte and then the opcode.
// PUSHF writes 2 or 4 bytes, POPF reads 2 or 4 (each byte read passes ST_READ, then ST_CAPT).
// INT and IRQ write 6 bytes and read 4 vector bytes; IRET adds a check state and reads 6 or 12.
// The result is held in an output register until taken; the next item is taken after that.
// Synchronous active-low reset clears control state and the exit registers; memory is not cleared.
`default_nettype none
module vm86_trap_emulator #(
  parameter int unsigned MEM_ADDR_BITS = v86_pkg::MEM_ADDR_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  v86_in_if.sink   in_ch,
  v86_out_if.source out_ch,
  v86_cfg_if.sink  cfg_ch
);
  import v86_pkg::*;

  localparam int unsigned AW = MEM_ADDR_BITS;

  state_t state_r, state_nxt;
  seq_t   seq_r, seq_nxt;

  logic [15:0] exit_ss_r, exit_sp_r;

  logic [1:0]  func_r, func_nxt;
  logic [31:0] ip_r, ip_nxt;
  logic [15:0] cs_r, cs_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic [15:0] ss_r, ss_nxt;
  logic [31:0] fl_r, fl_nxt;
  logic        op32_r, op32_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [7:0]  vec_r, vec_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic        ex_r, ex_nxt;
  logic        code_r, code_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic [3:0] nbytes;
  logic [15:0] wword;
  logic [AW-1:0] lin_ss_sp, lin_cs_ip;

  v86_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  function automatic logic [AW-1:0] lin(input logic [15:0] seg, input logic [31:0] off);
    logic [35:0] s;
    s = {16'd0, seg, 4'd0} + {4'd0, off};
    return s[AW-1:0];
  endfunction

  assign lin_ss_sp = lin(ss_r, {16'd0, sp_r});
  assign lin_cs_ip = lin(cs_r, ip_r);

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_ss_r <= '0;
      exit_sp_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_EXIT_SS) begin
        exit_ss_r <= cfg_ch.data;
      end else begin
        exit_sp_r <= cfg_ch.data;
      end
    end
  end

  // Bytes each sequence moves: stack pushes write words, others read.
  always_comb begin
    case (seq_r)
      SEQ_PUSHF: nbytes = op32_r ? 4'd4 : 4'd2;
      SEQ_POPF:  nbytes = op32_r ? 4'd4 : 4'd2;
      SEQ_INT:   nbytes = 4'd6;
      SEQ_IRET:  nbytes = op32_r ? 4'd12 : 4'd6;
      default:   nbytes = 4'd2;
    endcase
    case (step_r[2:1])
      2'd0:    wword = fl_r[15:0];
      2'd1:    wword = cs_r;
      default: wword = ip_r[15:0];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    seq_nxt = seq_r;
    func_nxt = func_r; ip_nxt = ip_r; cs_nxt = cs_r; sp_nxt = sp_r; ss_nxt = ss_r;
    fl_nxt = fl_r; op32_nxt = op32_r; cnt_nxt = cnt_r; step_nxt = step_r;
    vec_nxt = vec_r; acc_nxt = acc_r; rd_nxt = rd_r; ex_nxt = ex_r; code_nxt = code_r;
    addr_nxt = addr_r;
    ram_we = 1'b0;
    ram_addr = addr_r;
    ram_wdata = 8'd0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          func_nxt = in_ch.func;
          ip_nxt = in_ch.ip_in; cs_nxt = in_ch.code_seg_in;
          sp_nxt = in_ch.stack_ptr_in; ss_nxt = in_ch.stack_seg_in;
          fl_nxt = in_ch.flags_in;
          op32_nxt = 1'b0; cnt_nxt = '0; step_nxt = '0;
          ex_nxt = 1'b0; code_nxt = 1'b0; rd_nxt = '0; acc_nxt = '0;
          addr_nxt = in_ch.mem_addr[AW-1:0];
          ram_addr = in_ch.mem_addr[AW-1:0];
          case (in_ch.func)
            FUNC_WRITE: begin
              ram_we = 1'b1;
              ram_wdata = in_ch.mem_data;
              state_nxt = ST_DONE;
            end
            FUNC_READ: state_nxt = ST_MEMRD;
            FUNC_EMUL: begin
              ram_addr = lin(in_ch.code_seg_in, in_ch.ip_in);
              state_nxt = ST_FETCH;
            end
            default: begin
              vec_nxt = in_ch.irq_number[3] ? IRQ_HI_BASE + {5'd0, in_ch.irq_number[2:0]}
                                            : IRQ_LO_BASE + {4'd0, in_ch.irq_number};
              seq_nxt = SEQ_INT;
              state_nxt = ST_WRITE;
            end
          endcase
        end
      end
      ST_MEMRD: begin
        rd_nxt = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_FETCH: begin
        // Byte at cs:ip has arrived.
        ip_nxt = {16'd0, ip_r[15:0] + 16'd1};
        if (is_prefix(ram_rdata)) begin
          if (ram_rdata == OP_OPSZ) op32_nxt = 1'b1;
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == MAX_PREFIXES) begin
            ex_nxt = 1'b1; code_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            ram_addr = lin(cs_r, {16'd0, ip_r[15:0] + 16'd1});
          end
        end else begin
          state_nxt = ST_DONE;
          ram_addr = lin(cs_r, {16'd0, ip_r[15:0] + 16'd1});
          case (ram_rdata)
            OP_PUSHF: begin
              seq_nxt = SEQ_PUSHF;
              sp_nxt = sp_r - (op32_r ? 16'd4 : 16'd2);
              state_nxt = ST_WRITE;
            end
            OP_POPF: begin seq_nxt = SEQ_POPF; state_nxt = ST_READ; end
            OP_INT: state_nxt = ST_INTNUM;
            OP_IRET: begin seq_nxt = SEQ_IRET; state_nxt = ST_CHKIRET; end
            OP_CLI: fl_nxt = fl_r & ~FLAG_IF;
            OP_STI: fl_nxt = fl_r | FLAG_IF;
            OP_HLT: ;
            default: begin ex_nxt = 1'b1; code_nxt = 1'b1; end
          endcase
        end
      end
      ST_INTNUM: begin
        vec_nxt = ram_rdata;
        ip_nxt = {16'd0, ip_r[15:0] + 16'd1};
        seq_nxt = SEQ_INT;
        state_nxt = ST_WRITE;
      end
      ST_CHKIRET: begin
        if (ss_r == exit_ss_r && sp_r == exit_sp_r) begin
          ex_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_WRITE: begin
        // PUSHF: sp already lowered, bytes go upward from ss:sp.
        // INT/IRQ: each word goes to sp-2, low byte then high byte; sp is lowered with the high byte.
        ram_we = 1'b1;
        if (seq_r == SEQ_PUSHF) begin
          ram_addr = lin_ss_sp + AW'(step_r);
          ram_wdata = fl_r[8*step_r[1:0] +: 8];
        end else begin
          ram_addr = lin(ss_r, {16'd0, sp_r - 16'd2}) + AW'(step_r[0]);
          ram_wdata = step_r[0] ? wword[15:8] : wword[7:0];
          if (step_r[0]) sp_nxt = sp_r - 16'd2;
        end
        step_nxt = step_r + 4'd1;
        if (step_r == nbytes - 4'd1) begin
          step_nxt = '0;
          if (seq_r == SEQ_INT) begin
            fl_nxt = fl_r & ~FLAG_IF;
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: begin
        // Issue read of byte step; it lands in ST_CAPT.
        if (seq_r == SEQ_INT) begin
          ram_addr = AW'({22'd0, vec_r, 2'b00} + {28'd0, step_r});
        end else if (op32_r) begin
          ram_addr = lin_ss_sp + AW'(step_r[1:0]);
        end else begin
          ram_addr = lin_ss_sp + AW'(step_r[0]);
        end
        state_nxt = ST_CAPT;
      end
      ST_CAPT: begin
        acc_nxt = acc_r;
        if (seq_r != SEQ_INT && op32_r) begin
          acc_nxt[8*step_r[1:0] +: 8] = ram_rdata;
        end else begin
          acc_nxt[8*step_r[0] +: 8] = ram_rdata;
        end
        step_nxt = step_r + 4'd1;
        state_nxt = ST_READ;
        case (seq_r)
          SEQ_POPF: begin
            if (step_r == nbytes - 4'd1) begin
              fl_nxt = (op32_r ? acc_nxt : {16'd0, acc_nxt[15:0]}) | FLAG_VM;
              sp_nxt = sp_r + {12'd0, nbytes};
              state_nxt = ST_DONE;
            end
          end
          SEQ_INT: begin
            if (step_r == 4'd1) ip_nxt = {16'd0, acc_nxt[15:0]};
            if (step_r == 4'd3) begin
              cs_nxt = acc_nxt[15:0];
              state_nxt = ST_DONE;
            end
          end
          default: begin
            if (op32_r ? (step_r[1:0] == 2'd3) : step_r[0]) begin
              sp_nxt = sp_r + (op32_r ? 16'd4 : 16'd2);
              case (op32_r ? step_r[3:2] : step_r[2:1])
                2'd0: ip_nxt = op32_r ? acc_nxt : {16'd0, acc_nxt[15:0]};
                2'd1: cs_nxt = acc_nxt[15:0];
                default: begin
                  fl_nxt = op32_r ? acc_nxt : {fl_r[31:16], acc_nxt[15:0]};
                  state_nxt = ST_DONE;
                end
              endcase
            end
          end
        endcase
      end
      ST_DONE: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seq_r <= SEQ_PUSHF;
      step_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      seq_r <= seq_nxt;
      step_r <= step_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt; ip_r <= ip_nxt; cs_r <= cs_nxt; sp_r <= sp_nxt; ss_r <= ss_nxt;
    fl_r <= fl_nxt; op32_r <= op32_nxt; vec_r <= vec_nxt; acc_r <= acc_nxt;
    rd_r <= rd_nxt; ex_r <= ex_nxt; code_r <= code_nxt; addr_r <= addr_nxt;
  end

  logic mem_func;
  assign mem_func = (func_r == FUNC_WRITE) || (func_r == FUNC_READ);

  assign in_ch.ready = (state_r == ST_IDLE);
  always_comb begin
    out_ch.valid = (state_r == ST_DONE);
    out_ch.ip_out = mem_func ? 32'd0 : ip_r;
    out_ch.code_seg_out = mem_func ? 16'd0 : cs_r;
    out_ch.stack_ptr_out = mem_func ? 16'd0 : sp_r;
    out_ch.flags_out = mem_func ? 32'd0 : fl_r;
    out_ch.exit_monitor = ex_r;
    out_ch.exit_code = code_r;
    out_ch.read_data = (func_r == FUNC_READ) ? rd_r : 8'd0;
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("input taken while result pending");
  a_code_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.exit_code |-> out_ch.exit_monitor)
    else $error("exit code without exit");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped before taken");
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_PREFIXES + 5'd1) else $error("prefix count overflow");
endmodule
`default_nettype wire

// File: dv/v86_trap_test_if.sv
// Transaction types used by the testbench.
`timescale 1ns / 1ps
package v86_trap_test_pkg;
  typedef struct packed {
    logic [1:0]  func;
    logic [19:0] mem_addr;
    logic [7:0]  mem_data;
    logic [3:0]  irq_number;
    logic [31:0] ip;
    logic [15:0] cs;
    logic [15:0] sp;
    logic [15:0] ss;
    logic [31:0] flags;
  } trap_req_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] cs;
    logic [15:0] sp;
    logic [31:0] flags;
    logic        exit_monitor;
    logic        exit_code;
    logic [7:0]  read_data;
  } trap_resp_t;
endpackage

// File: dv/vm86_trap_emulator_test.sv
// Self-checking testbench of the trap emulator: directed and random guest programs against a predictor.
`timescale 1ns / 1ps
module vm86_trap_emulator_test;
  import v86_pkg::*;
  import v86_trap_test_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  v86_in_if  in_ch ();
  v86_out_if out_ch ();
  v86_cfg_if cfg_ch ();

  vm86_trap_emulator u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_ch(cfg_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a sparse copy of guest memory and the exit registers.
  logic [7:0]  guest_mem [logic [19:0]];
  logic [15:0] exit_ss_q, exit_sp_q;
  bit written [logic [19:0]];

  trap_req_t  pending_reqs [$];
  trap_resp_t expected_resps [$];
  int  mismatches = 0;
  bit  failed = 1'b0;
  int  hold_left = 0;
  bit  drain_pause = 1'b0;
  bit  in_fired = 1'b0;

  function automatic logic [19:0] lin(input logic [15:0] seg, input logic [31:0] off);
    return 20'(({16'h0, seg} << 4) + off);
  endfunction

  function automatic logic [7:0] mem_rd(input logic [19:0] a);
    return guest_mem.exists(a) ? guest_mem[a] : 8'h00;
  endfunction

  function automatic logic [31:0] mem_rd_n(input logic [15:0] seg, input logic [31:0] off,
                                           input int n);
    logic [19:0] base;
    logic [31:0] v;
    base = lin(seg, off);
    v = '0;
    for (int i = n - 1; i >= 0; i--) v = (v << 8) | {24'h0, mem_rd(20'(base + i))};
    return v;
  endfunction

  function automatic void mem_wr_n(input logic [15:0] seg, input logic [15:0] off,
                                   input logic [31:0] v, input int n);
    logic [19:0] base;
    base = lin(seg, {16'h0, off});
    for (int i = 0; i < n; i++) guest_mem[20'(base + i)] = v[8*i +: 8];
  endfunction

  function automatic bit prefix_byte(input logic [7:0] b);
    return b == 8'h26 || b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h64 ||
           b == 8'h65 || b == OP_OPSZ || b == 8'h67 || b == 8'hF0 || b == 8'hF2 ||
           b == 8'hF3;
  endfunction

  function automatic logic [7:0] irq_vector(input logic [3:0] irq);
    return irq[3] ? IRQ_HI_BASE + {5'h0, irq[2:0]} : IRQ_LO_BASE + {4'h0, irq};
  endfunction

  function automatic void push_frame(input logic [15:0] ss, inout logic [15:0] sp,
                                     input logic [31:0] fl, input logic [15:0] cs,
                                     input logic [31:0] ip);
    sp -= 16'd2; mem_wr_n(ss, sp, {16'h0, fl[15:0]}, 2);
    sp -= 16'd2; mem_wr_n(ss, sp, {16'h0, cs}, 2);
    sp -= 16'd2; mem_wr_n(ss, sp, {16'h0, ip[15:0]}, 2);
  endfunction

  function automatic trap_resp_t emulate_trap(input trap_req_t r);
    trap_resp_t o;
    logic [31:0] ip, fl;
    logic [15:0] cs, sp;
    logic [7:0]  op, vec;
    bit op32;
    int cnt;
    o = '0;
    ip = r.ip; cs = r.cs; sp = r.sp; fl = r.flags;
    if (r.func == FUNC_WRITE || r.func == FUNC_READ) begin
      if (r.func == FUNC_WRITE) guest_mem[r.mem_addr] = r.mem_data;
      else o.read_data = mem_rd(r.mem_addr);
      return o;
    end
    if (r.func == FUNC_IRQ) begin
      vec = irq_vector(r.irq_number);
      push_frame(r.ss, sp, fl, cs, ip);
      fl &= ~FLAG_IF;
      ip = mem_rd_n(16'h0, {22'h0, vec, 2'b00}, 2);
      cs = 16'(mem_rd_n(16'h0, {22'h0, vec, 2'b00} + 32'd2, 2));
    end else begin
      op32 = 1'b0;
      cnt = 0;
      forever begin
        op = mem_rd(lin(cs, ip));
        ip = {16'h0, 16'(ip + 32'd1)};
        if (!prefix_byte(op)) break;
        if (op == OP_OPSZ) op32 = 1'b1;
        cnt++;
        if (cnt > 15) break;
      end
      if (prefix_byte(op)) begin
        o.exit_monitor = 1'b1; o.exit_code = 1'b1;
      end else begin
        case (op)
          OP_PUSHF: begin
            if (op32) begin sp -= 16'd4; mem_wr_n(r.ss, sp, fl, 4); end
            else begin sp -= 16'd2; mem_wr_n(r.ss, sp, {16'h0, fl[15:0]}, 2); end
          end
          OP_POPF: begin
            if (op32) begin fl = mem_rd_n(r.ss, {16'h0, sp}, 4) | FLAG_VM; sp += 16'd4; end
            else begin fl = mem_rd_n(r.ss, {16'h0, sp}, 2) | FLAG_VM; sp += 16'd2; end
          end
          OP_INT: begin
            vec = mem_rd(lin(cs, ip));
            ip = {16'h0, 16'(ip + 32'd1)};
            push_frame(r.ss, sp, fl, cs, ip);
            fl &= ~FLAG_IF;
            ip = mem_rd_n(16'h0, {22'h0, vec, 2'b00}, 2);
            cs = 16'(mem_rd_n(16'h0, {22'h0, vec, 2'b00} + 32'd2, 2));
          end
          OP_IRET: begin
            if (r.ss == exit_ss_q && sp == exit_sp_q) begin
              o.exit_monitor = 1'b1;
            end else if (op32) begin
              ip = mem_rd_n(r.ss, {16'h0, sp}, 4); sp += 16'd4;
              cs = 16'(mem_rd_n(r.ss, {16'h0, sp}, 4)); sp += 16'd4;
              fl = mem_rd_n(r.ss, {16'h0, sp}, 4); sp += 16'd4;
            end else begin
              ip = mem_rd_n(r.ss, {16'h0, sp}, 2); sp += 16'd2;
              cs = 16'(mem_rd_n(r.ss, {16'h0, sp}, 2)); sp += 16'd2;
              fl = {fl[31:16], 16'(mem_rd_n(r.ss, {16'h0, sp}, 2))}; sp += 16'd2;
            end
          end
          OP_CLI: fl &= ~FLAG_IF;
          OP_STI: fl |= FLAG_IF;
          OP_HLT: ;
          default: begin o.exit_monitor = 1'b1; o.exit_code = 1'b1; end
        endcase
      end
    end
    o.ip = ip; o.cs = cs; o.sp = sp; o.flags = fl;
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: accepted beats go straight to the predictor.
  int in_gap = 0;
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      expected_resps.push_back(emulate_trap(pending_reqs.pop_front()));
      in_fired = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fired) begin
      // The beat is still on offer.
    end else begin
      in_fired = 1'b0;
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !drain_pause) begin
        in_ch.valid        <= 1'b1;
        in_ch.func         <= pending_reqs[0].func;
        in_ch.mem_addr     <= pending_reqs[0].mem_addr;
        in_ch.mem_data     <= pending_reqs[0].mem_data;
        in_ch.irq_number   <= pending_reqs[0].irq_number;
        in_ch.ip_in        <= pending_reqs[0].ip;
        in_ch.code_seg_in  <= pending_reqs[0].cs;
        in_ch.stack_ptr_in <= pending_reqs[0].sp;
        in_ch.stack_seg_in <= pending_reqs[0].ss;
        in_ch.flags_in     <= pending_reqs[0].flags;
        in_gap <= gap_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor.
  int out_gap = 0;
  always @(posedge clk) begin
    trap_resp_t got, exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.ip_out, out_ch.code_seg_out, out_ch.stack_ptr_out, out_ch.flags_out,
              out_ch.exit_monitor, out_ch.exit_code, out_ch.read_data};
      if (expected_resps.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", got);
      end else begin
        exp_r = expected_resps.pop_front();
        if (got !== exp_r) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  // The receiver counts down its own hold-off stretch.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap <= gap_len();
    end
  end

  // Stimulus helpers: every beat is queued, then predicted when accepted.
  function automatic trap_req_t blank_req();
    trap_req_t r;
    r = '0;
    r.ip = $urandom; r.cs = 16'($urandom); r.sp = 16'($urandom); r.ss = 16'($urandom);
    r.flags = $urandom; r.mem_addr = 20'($urandom); r.mem_data = 8'($urandom);
    r.irq_number = 4'($urandom);
    return r;
  endfunction

  task automatic put_byte(input logic [19:0] a, input logic [7:0] d);
    trap_req_t r;
    r = blank_req();
    r.func = FUNC_WRITE; r.mem_addr = a; r.mem_data = d;
    pending_reqs.push_back(r);
    written[a] = 1'b1;
  endtask

  task automatic read_back(input logic [19:0] a);
    trap_req_t r;
    r = blank_req();
    r.func = FUNC_READ; r.mem_addr = a;
    pending_reqs.push_back(r);
  endtask

  task automatic fill(input logic [19:0] a, input int n);
    for (int i = 0; i < n; i++) put_byte(20'(a + i), 8'($urandom));
  endtask

  // Lays out a trapped instruction, its stack and vectors, then queues the emulate beat.
  task automatic queue_trap(input logic [7:0] opc, input int npfx, input bit opsz,
                            input logic [31:0] ip, input logic [15:0] cs,
                            input logic [15:0] sp, input logic [15:0] ss,
                            input logic [31:0] fl);
    trap_req_t r;
    logic [15:0] p;
    logic [7:0] pfx, vec;
    p = ip[15:0];
    put_byte(lin(cs, ip), (npfx > 0) ? (opsz ? OP_OPSZ : 8'hF3) : opc);
    if (npfx > 0) begin
      p = p + 16'd1;
      for (int i = 1; i < npfx; i++) begin
        pfx = ($urandom_range(0, 3) == 0) ? OP_OPSZ : 8'h2E;
        put_byte(lin(cs, {16'h0, p}), pfx);
        p = p + 16'd1;
      end
      put_byte(lin(cs, {16'h0, p}), opc);
    end
    p = p + 16'd1;
    vec = 8'($urandom);
    if (opc == OP_INT) begin
      put_byte(lin(cs, {16'h0, p}), vec);
      fill({10'h0, vec, 2'b00}, 4);
    end
    if (opc == OP_POPF || opc == OP_IRET) fill(lin(ss, {16'h0, sp}), 12);
    r = blank_req();
    r.func = FUNC_EMUL; r.ip = ip; r.cs = cs; r.sp = sp; r.ss = ss; r.flags = fl;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_irq(input logic [3:0] irq, input logic [15:0] sp,
                           input logic [15:0] ss);
    trap_req_t r;
    logic [7:0] vec;
    vec = irq_vector(irq);
    fill({10'h0, vec, 2'b00}, 4);
    r = blank_req();
    r.func = FUNC_IRQ; r.irq_number = irq; r.sp = sp; r.ss = ss;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_EXIT_SS) exit_ss_q = val; else exit_sp_q = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 7))
      0: return OP_PUSHF;
      1: return OP_POPF;
      2: return OP_INT;
      3: return OP_IRET;
      4: return OP_CLI;
      5: return OP_STI;
      6: return OP_HLT;
      default: return 8'h90;
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [15:0] ex_ss, ex_sp;
    logic [19:0] a;
    logic [19:0] keys [$];
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          a = 20'($urandom);
          put_byte(a, 8'($urandom));
        end
        1: begin
          keys.delete();
          foreach (written[key]) if (keys.size() < 64) keys.push_back(key);
          if (keys.size() > 0) read_back(keys[$urandom_range(0, keys.size() - 1)]);
        end
        2: queue_irq(4'($urandom), 16'($urandom), 16'($urandom));
        3: begin
          // IRET right at the session origin.
          ex_ss = exit_ss_q; ex_sp = exit_sp_q;
          queue_trap(OP_IRET, $urandom_range(0, 2), 1'($urandom), $urandom, 16'($urandom),
                     ex_sp, ex_ss, $urandom);
        end
        default: queue_trap(pick_op(), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0,
                            1'($urandom), $urandom, 16'($urandom), 16'($urandom),
                            16'($urandom), $urandom);
      endcase
    end
  endtask

  initial begin
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_EXIT_SS; cfg_ch.data = '0;
    in_ch.valid = 1'b0; in_ch.func = FUNC_WRITE; in_ch.mem_addr = '0; in_ch.mem_data = '0;
    in_ch.irq_number = '0; in_ch.ip_in = '0; in_ch.code_seg_in = '0;
    in_ch.stack_ptr_in = '0; in_ch.stack_seg_in = '0; in_ch.flags_in = '0;
    out_ch.ready = 1'b0;
    exit_ss_q = '0; exit_sp_q = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: every operation, field extremes, prefix overflow, both IRET forms.
    write_reg(CFG_EXIT_SS, 16'hFFFF);
    write_reg(CFG_EXIT_SP, 16'hFFFF);
    put_byte(20'hFFFFF, 8'hFF); read_back(20'hFFFFF);
    put_byte(20'h00000, 8'h00); read_back(20'h00000);
    queue_trap(OP_PUSHF, 0, 0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    queue_trap(OP_PUSHF, 1, 1, 32'h0, 16'h0, 16'h0002, 16'h0, 32'h0);
    queue_trap(OP_POPF, 0, 0, 32'h1234, 16'h1000, 16'hFFFF, 16'h2000, 32'h0);
    queue_trap(OP_POPF, 1, 1, 32'h1234, 16'h1000, 16'hFFFE, 16'h2000, 32'h0);
    queue_trap(OP_INT, 0, 0, 32'h0000_FFFF, 16'h3000, 16'h0004, 16'h4000, 32'hFFFF_FFFF);
    queue_trap(OP_IRET, 0, 0, 32'h50, 16'h5000, 16'hFFF8, 16'h6000, 32'hFFFF_0000);
    queue_trap(OP_IRET, 1, 1, 32'h50, 16'h5000, 16'h0010, 16'h6000, 32'h0);
    queue_trap(OP_IRET, 0, 0, 32'h60, 16'h5000, 16'hFFFF, 16'hFFFF, 32'h0);
    queue_trap(OP_CLI, 2, 0, 32'h70, 16'h5000, 16'h0, 16'h0, 32'hFFFF_FFFF);
    queue_trap(OP_STI, 0, 0, 32'h80, 16'h5000, 16'h0, 16'h0, 32'h0);
    queue_trap(OP_HLT, 15, 1, 32'h90, 16'h7000, 16'h0, 16'h0, 32'h0);
    queue_trap(OP_HLT, 16, 0, 32'hA0, 16'h7100, 16'h0, 16'h0, 32'h0);
    queue_trap(8'h90, 0, 0, 32'hC0, 16'h7200, 16'h0, 16'h0, 32'h0);
    queue_irq(4'd0, 16'h0000, 16'hFFFF);
    queue_irq(4'd7, 16'h1000, 16'h0);
    queue_irq(4'd8, 16'h1000, 16'h0);
    queue_irq(4'd15, 16'hFFFF, 16'h8000);
    wait_drained();

    // The receiver holds off so the block fills up and stalls its input.
    hold_left = 300;
    random_phase(6);
    wait (hold_left == 0);
    wait_drained();

    write_reg(CFG_EXIT_SS, 16'h0000);
    write_reg(CFG_EXIT_SP, 16'h0000);
    random_phase(60);
    repeat (150) @(posedge clk);
    // The sender pauses until every outstanding result has come back.
    drain_pause = 1'b1;
    while (expected_resps.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (20) @(posedge clk);
    drain_pause = 1'b0;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_EXIT_SS, 16'($urandom));
      write_reg(CFG_EXIT_SP, 16'($urandom));
      random_phase(16);
      wait_drained();
    end

    if (!failed && mismatches == 0 && expected_resps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
